// ===== design/sem_pkg.sv =====
// shared types, constants and the square root step for the sobel edge magnitude block
// no dependencies; imported by every module of the block

package sem_pkg;

   localparam int DIM_W       = 11;
   localparam int PIX_W       = 8;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = DIM_W;
   localparam int REQ_DATA_W  = 2 * PIX_W;
   localparam int RSP_DATA_W  = 2 * PIX_W;

   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

   localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = 11'd480;
   localparam logic [DIM_W-1:0] ROW_LIMIT          = '1;

   localparam int MAG_W  = PIX_W + 2;
   localparam int GRAD_W = MAG_W + 2;
   localparam int SQ_W   = 2 * MAG_W;
   localparam int SUM_W  = SQ_W + 1;
   localparam int REM_W  = 2 * PIX_W;
   localparam int ROOT_W = PIX_W;
   localparam int ROOT_STAGES = ROOT_W / 2;

   localparam logic [PIX_W-1:0] LEVEL_SAT = '1;

   typedef struct packed {
      logic [PIX_W-1:0] older;
      logic [PIX_W-1:0] alpha;
      logic [PIX_W-1:0] gray;
   } sem_entry_type;

   typedef struct packed {
      logic top_m;
      logic bot_m;
      logic left_m;
      logic right_m;
      logic emit;
      logic done;
   } sem_ctl_type;

   typedef struct packed {
      logic [PIX_W-1:0] alpha;
      logic             done;
   } sem_tag_type;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sem_root_type;

   // one restoring digit of the integer square root, bit k of the result
   function automatic sem_root_type root_step(sem_root_type cur, int k);
      logic [REM_W-1:0] trial;
      sem_root_type     nxt;
      trial = (REM_W'(cur.root) << (k + 1)) | (REM_W'(1) << (2 * k));
      nxt   = cur;
      if (cur.rem >= trial) begin
         nxt.rem  = cur.rem - trial;
         nxt.root = cur.root | (ROOT_W'(1) << k);
      end
      return nxt;
   endfunction

endpackage

// ===== design/sem_line_store.sv =====
// two line stores in one synchronous memory: row above (gray, alpha) and row two above (gray)
// clears itself after reset; write-to-read bypass for back-to-back access to one column
// depends on sem_pkg

module sem_line_store import sem_pkg::*; #(
   parameter int DEPTH = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output sem_entry_type              rd_data,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  sem_entry_type              wr_data,
   output logic                       busy
);

   localparam int AW = $clog2(DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   sem_entry_type mem [0:DEPTH-1];

   sem_entry_type mem_q_ff;
   sem_entry_type fwd_ff;
   logic          hit_ff;
   logic          clr_ff;
   logic [AW-1:0] clr_addr_ff;

   logic          mem_we;
   logic [AW-1:0] mem_wa;
   sem_entry_type mem_wd;

   assign busy = clr_ff;

   always_comb begin
      mem_we = wr_en;
      mem_wa = wr_addr;
      mem_wd = wr_data;
      if (clr_ff) begin
         mem_we = 1'b1;
         mem_wa = clr_addr_ff;
         mem_wd = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         mem_q_ff <= mem[rd_addr];
         fwd_ff   <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff      <= 1'b0;
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         if (rd_en) begin
            hit_ff <= wr_en && (wr_addr == rd_addr);
         end
         if (clr_ff) begin
            if (clr_addr_ff == LAST_ADDR) begin
               clr_ff <= 1'b0;
            end else begin
               clr_addr_ff <= clr_addr_ff + AW'(1);
            end
         end
      end
   end

   assign rd_data = hit_ff ? fwd_ff : mem_q_ff;

endmodule

// ===== design/sem_window.sv =====
// 3x3 gray window with edge masking and the horizontal and vertical sobel sums
// depends on sem_pkg

module sem_window import sem_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_valid,
   input  sem_ctl_type              in_ctl,
   input  sem_entry_type            in_line,
   input  logic [PIX_W-1:0]         in_gray,
   output logic                     out_valid,
   output logic signed [GRAD_W-1:0] out_gx,
   output logic signed [GRAD_W-1:0] out_gy,
   output sem_tag_type              out_tag
);

   typedef logic [2:0][PIX_W-1:0] sem_col_type;

   sem_col_type      col_a_ff;
   sem_col_type      col_b_ff;
   logic [PIX_W-1:0] line_alpha_ff;

   sem_col_type      new_col;
   sem_col_type      win [3];
   logic [PIX_W-1:0] m [3][3];
   logic [MAG_W-1:0] x_pos, x_neg, y_pos, y_neg;
   logic signed [GRAD_W-1:0] gx, gy;

   // rows top to bottom: two rows above, row above, incoming row
   assign new_col = {in_gray, in_line.gray, in_line.older};

   always_comb begin
      win[0] = col_a_ff;
      win[1] = col_b_ff;
      win[2] = new_col;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if ((r == 0 && in_ctl.top_m) || (r == 2 && in_ctl.bot_m) ||
                (c == 0 && in_ctl.left_m) || (c == 2 && in_ctl.right_m)) begin
               m[r][c] = '0;
            end else begin
               m[r][c] = win[c][r];
            end
         end
      end
      x_pos = {2'b00, m[0][0]} + {1'b0, m[1][0], 1'b0} + {2'b00, m[2][0]};
      x_neg = {2'b00, m[0][2]} + {1'b0, m[1][2], 1'b0} + {2'b00, m[2][2]};
      y_pos = {2'b00, m[0][0]} + {1'b0, m[0][1], 1'b0} + {2'b00, m[0][2]};
      y_neg = {2'b00, m[2][0]} + {1'b0, m[2][1], 1'b0} + {2'b00, m[2][2]};
      gx = $signed({2'b00, x_pos}) - $signed({2'b00, x_neg});
      gy = $signed({2'b00, y_pos}) - $signed({2'b00, y_neg});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid     <= 1'b0;
         col_a_ff      <= '0;
         col_b_ff      <= '0;
         line_alpha_ff <= '0;
      end else if (adv) begin
         out_valid <= in_valid && in_ctl.emit;
         if (in_valid) begin
            col_a_ff      <= col_b_ff;
            col_b_ff      <= new_col;
            line_alpha_ff <= in_line.alpha;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_gx        <= gx;
         out_gy        <= gy;
         out_tag.alpha <= line_alpha_ff;
         out_tag.done  <= in_ctl.done;
      end
   end

endmodule

// ===== design/sem_isqrt.sv =====
// squared gradient sum and a pipelined integer square root, two result bits per stage
// depends on sem_pkg

module sem_isqrt import sem_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_valid,
   input  logic signed [GRAD_W-1:0] in_gx,
   input  logic signed [GRAD_W-1:0] in_gy,
   input  sem_tag_type              in_tag,
   output logic                     out_valid,
   output logic [PIX_W-1:0]         out_level,
   output sem_tag_type              out_tag
);

   logic         v_ff   [0:ROOT_STAGES];
   sem_root_type rt_ff  [0:ROOT_STAGES];
   logic         sat_ff [0:ROOT_STAGES];
   sem_tag_type  tag_ff [0:ROOT_STAGES];

   logic signed [GRAD_W-1:0] neg_x, neg_y;
   logic [MAG_W-1:0] ax, ay;
   logic [SQ_W-1:0]  px, py;
   logic [SUM_W-1:0] sum;

   always_comb begin
      neg_x = -in_gx;
      neg_y = -in_gy;
      ax  = in_gx[GRAD_W-1] ? neg_x[MAG_W-1:0] : in_gx[MAG_W-1:0];
      ay  = in_gy[GRAD_W-1] ? neg_y[MAG_W-1:0] : in_gy[MAG_W-1:0];
      px  = SQ_W'(ax) * SQ_W'(ax);
      py  = SQ_W'(ay) * SQ_W'(ay);
      sum = SUM_W'(px) + SUM_W'(py);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= ROOT_STAGES; j++) begin
            v_ff[j] <= 1'b0;
         end
      end else if (adv) begin
         v_ff[0] <= in_valid;
         for (int j = 0; j < ROOT_STAGES; j++) begin
            v_ff[j+1] <= v_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rt_ff[0].rem  <= sum[REM_W-1:0];
         rt_ff[0].root <= '0;
         sat_ff[0]     <= |sum[SUM_W-1:REM_W];
         tag_ff[0]     <= in_tag;
         for (int j = 0; j < ROOT_STAGES; j++) begin
            rt_ff[j+1]  <= root_step(root_step(rt_ff[j], ROOT_W - 1 - 2 * j),
                                     ROOT_W - 2 - 2 * j);
            sat_ff[j+1] <= sat_ff[j];
            tag_ff[j+1] <= tag_ff[j];
         end
      end
   end

   assign out_valid = v_ff[ROOT_STAGES];
   assign out_level = sat_ff[ROOT_STAGES] ? LEVEL_SAT : rt_ff[ROOT_STAGES].root;
   assign out_tag   = tag_ff[ROOT_STAGES];

endmodule

// ===== design/sobel_edge_magnitude.sv =====
// Sobel 3x3 gradient magnitude over a raster stream of gray pixels with alpha.
// Channels: req_ carries one pixel word per handshake (gray, alpha); rsp_ returns
// one word per centre pixel (edge level, centre alpha) with rsp_tlast on the
// frame's last pixel; csr_ writes frame_width (index 0) and frame_height (index 1),
// always ready; the host must write it only while the block is idle (not enforced).
// A centre's result depends on the pixel one row plus one column later, so the
// first frame_width+1 words of a frame give no result, and after a frame the
// host sends frame_width+1 trailing words whose values are ignored.
// Throughput: one word per cycle unless rsp_ stalls or the memory clears, set by the
// line memory's single read and single write port (read at acceptance, written back
// at the next advance). A result passes the a_, window, root and output registers.
// Reset: the line memory clears one column per cycle, all MAX_WIDTH columns, with
// req_tready low; sizes return to 640 x 480 and the scan to row 0, column 0.
// Stall: while a result waits on rsp_tready the whole pipeline holds and
// req_tready stays low; nothing is dropped.
// depends on sem_pkg, sem_line_store, sem_window, sem_isqrt

module sobel_edge_magnitude import sem_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // pixel_gray, pixel_alpha
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // edge_level, edge_alpha
   output logic                   rsp_tlast,   // frame_done
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int XW = (CW > DIM_W) ? CW : DIM_W;

   logic [DIM_W-1:0] frame_width_ff, frame_height_ff;
   logic [CW-1:0]    col_ff, col_in;
   logic [DIM_W-1:0] row_ff, row_in;

   logic             a_valid_ff;
   sem_ctl_type      a_ctl_ff;
   logic [CW-1:0]    a_idx_ff;
   logic [PIX_W-1:0] a_gray_ff, a_alpha_ff;

   logic             rsp_valid_ff, rsp_last_ff;
   logic [PIX_W-1:0] rsp_level_ff, rsp_alpha_ff;

   logic             adv, accept, busy;
   logic [DIM_W-1:0] w_eff, h_eff, wm1, hm1, cr;
   logic [CW-1:0]    cc;
   logic             col_last;
   sem_ctl_type      ctl_in;
   sem_entry_type    line_rd, line_wd;

   logic                     win_valid;
   logic signed [GRAD_W-1:0] win_gx, win_gy;
   sem_tag_type              win_tag;
   logic                     sq_valid;
   logic [PIX_W-1:0]         sq_level;
   sem_tag_type              sq_tag;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv && !busy;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // sizes, clamped to 1..max
   always_comb begin
      w_eff = frame_width_ff;
      if (frame_width_ff == '0) begin
         w_eff = DIM_W'(1);
      end else if (32'(frame_width_ff) > MAX_WIDTH) begin
         w_eff = DIM_W'(MAX_WIDTH);
      end
      h_eff = frame_height_ff;
      if (frame_height_ff == '0) begin
         h_eff = DIM_W'(1);
      end else if (32'(frame_height_ff) > MAX_HEIGHT) begin
         h_eff = DIM_W'(MAX_HEIGHT);
      end
      wm1 = w_eff - DIM_W'(1);
      hm1 = h_eff - DIM_W'(1);
   end

   // centre position of the incoming word and the scan advance
   always_comb begin
      col_last = XW'(col_ff) >= XW'(wm1);
      if (col_ff != '0) begin
         cr = row_ff - DIM_W'(1);
         cc = col_ff - CW'(1);
      end else begin
         cr = row_ff - DIM_W'(2);
         cc = CW'(wm1);
      end
      ctl_in.emit    = (row_ff >= DIM_W'(2)) || (row_ff == DIM_W'(1) && col_ff != '0);
      ctl_in.top_m   = cr == '0;
      ctl_in.bot_m   = cr >= hm1;
      ctl_in.left_m  = cc == '0;
      ctl_in.right_m = XW'(cc) >= XW'(wm1);
      ctl_in.done    = ctl_in.emit && ctl_in.bot_m && ctl_in.right_m;

      col_in = col_ff + CW'(1);
      row_in = row_ff;
      if (ctl_in.done) begin
         col_in = '0;
         row_in = '0;
      end else if (col_last) begin
         col_in = '0;
         if (row_ff != ROW_LIMIT) begin
            row_in = row_ff + DIM_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         col_ff          <= '0;
         row_ff          <= '0;
         a_valid_ff      <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_FRAME_WIDTH:  frame_width_ff  <= csr_data;
               REG_FRAME_HEIGHT: frame_height_ff <= csr_data;
               default: ;
            endcase
         end
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (adv) begin
            a_valid_ff <= accept;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_ctl_ff   <= ctl_in;
         a_idx_ff   <= col_ff;
         a_gray_ff  <= req_tdata[PIX_W-1:0];
         a_alpha_ff <= req_tdata[REQ_DATA_W-1:PIX_W];
      end
   end

   // the row above moves down into the older store, the new word into the recent one
   assign line_wd = '{older: line_rd.gray, alpha: a_alpha_ff, gray: a_gray_ff};

   sem_line_store #(
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (line_rd),
      .wr_en   (adv && a_valid_ff),
      .wr_addr (a_idx_ff),
      .wr_data (line_wd),
      .busy    (busy)
   );

   sem_window u_window (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (a_valid_ff),
      .in_ctl    (a_ctl_ff),
      .in_line   (line_rd),
      .in_gray   (a_gray_ff),
      .out_valid (win_valid),
      .out_gx    (win_gx),
      .out_gy    (win_gy),
      .out_tag   (win_tag)
   );

   sem_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (win_valid),
      .in_gx     (win_gx),
      .in_gy     (win_gy),
      .in_tag    (win_tag),
      .out_valid (sq_valid),
      .out_level (sq_level),
      .out_tag   (sq_tag)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= sq_valid;
         rsp_last_ff  <= sq_valid && sq_tag.done;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_level_ff <= sq_level;
         rsp_alpha_ff <= sq_tag.alpha;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_alpha_ff, rsp_level_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== design/sem_checker.sv =====
// port-level checks for sobel_edge_magnitude, attached by bind
// depends on sem_pkg and the top level's port names

module sem_checker import sem_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   // nothing in or out right after reset, the line memory is being cleared
   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (!rsp_tvalid && !req_tready))
      else $error("block active right after reset");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("result word changed while stalled");

   // a stalled output blocks the input side
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input accepted while output stalled");

   // end of frame only marks a valid word
   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> !rsp_tlast)
      else $error("frame end without a result word");

endmodule

bind sobel_edge_magnitude sem_checker u_sem_checker (.*);

// ===== verif/tb_sobel_edge_magnitude.sv =====
// testbench for sobel_edge_magnitude: a directed table of pixel words and frame sizes, then random frame
// sizes and pixel words, each result word checked against a behavioral predictor or the table's word
// depends on sem_pkg and the design sources; random stalls on the req_ and rsp_ channels

module tb_sobel_edge_magnitude;
   timeunit 1ns;
   timeprecision 1ps;
   import sem_pkg::*;

   localparam int MAX_W        = 1024;
   localparam int MAX_H        = 1024;
   localparam int DRAIN_CYCLES = 16;

   typedef struct packed {
      logic [PIX_W-1:0] level;
      logic [PIX_W-1:0] alpha;
      logic             done;
   } edge_word_type;

   typedef enum logic {ROW_PIXEL, ROW_SIZES} row_kind_type;

   typedef struct packed {
      row_kind_type     kind;
      logic [DIM_W-1:0] a;      // gray or frame width
      logic [DIM_W-1:0] b;      // alpha or frame height
      logic             typed;
      edge_word_type    want;
   } stim_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   // predictor state
   logic [2*PIX_W-1:0] line_above [MAX_W];
   logic [PIX_W-1:0]   line_two_above [MAX_W];
   logic [PIX_W-1:0]   window3 [9];
   logic [PIX_W-1:0]   alpha_lag [2];
   int unsigned        scan_col;
   int unsigned        scan_row;
   logic [DIM_W-1:0]   cfg_width;
   logic [DIM_W-1:0]   cfg_height;

   edge_word_type  edge_words_due [$];
   edge_word_type  next_due;
   stim_row_type   directed_rows [$];
   int             mismatch_count = 0;
   int             items_sent = 0;
   bit             idle_en = 1'b1;
   int unsigned    sink_hold_cycles = 0;

   sobel_edge_magnitude #(
      .MAX_WIDTH (MAX_W),
      .MAX_HEIGHT(MAX_H)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #6_000_000;
      $display("timeout at %0t ns", $time);
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic int unsigned effective_dim(input logic [DIM_W-1:0] v,
                                                 input int unsigned cap);
      if (v == 0) return 1;
      if (v > cap) return cap;
      return 32'(v);
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic predict_pixel(input logic [PIX_W-1:0] gray, input logic [PIX_W-1:0] alpha,
                                output bit emit, output edge_word_type word);
      int unsigned        w, h, ic, ir, cr, cc, s, root, t;
      int                 gx, gy, p, r, c, k;
      logic [2*PIX_W-1:0] rec;
      logic [PIX_W-1:0]   old;
      w  = effective_dim(cfg_width, MAX_W);
      h  = effective_dim(cfg_height, MAX_H);
      ic = scan_col;
      ir = scan_row;
      rec = line_above[ic];
      old = line_two_above[ic];
      for (r = 0; r < 3; r++) begin
         window3[r*3]   = window3[r*3+1];
         window3[r*3+1] = window3[r*3+2];
      end
      window3[2] = old;
      window3[5] = rec[PIX_W-1:0];
      window3[8] = gray;
      alpha_lag[0] = alpha_lag[1];
      alpha_lag[1] = rec[2*PIX_W-1:PIX_W];
      line_two_above[ic] = rec[PIX_W-1:0];
      line_above[ic]     = {alpha, gray};
      emit = (ir >= 2) || (ir == 1 && ic >= 1);
      word = '0;
      if (emit) begin
         if (ic > 0) begin
            cr = ir - 1;
            cc = ic - 1;
         end else begin
            cr = ir - 2;
            cc = w - 1;
         end
         gx = 0;
         gy = 0;
         // neighbors outside the frame are masked to zero
         for (r = 0; r < 3; r++) begin
            for (c = 0; c < 3; c++) begin
               if ((r == 0 && cr == 0) || (r == 2 && cr + 1 >= h) ||
                   (c == 0 && cc == 0) || (c == 2 && cc + 1 >= w)) continue;
               p  = int'(window3[r*3+c]);
               gx += p * (c == 0 ? 1 : c == 2 ? -1 : 0) * (r == 1 ? 2 : 1);
               gy += p * (r == 0 ? 1 : r == 2 ? -1 : 0) * (c == 1 ? 2 : 1);
            end
         end
         s = gx * gx + gy * gy;
         root = 0;
         for (k = 11; k >= 0; k--) begin
            t = root | (1 << k);
            if (t * t <= s) root = t;
         end
         word.level = (s >= 65536) ? LEVEL_SAT : root[PIX_W-1:0];
         word.alpha = alpha_lag[0];
         word.done  = (cr + 1 >= h) && (cc + 1 >= w);
      end
      if (word.done) begin
         scan_col = 0;
         scan_row = 0;
      end else if (ic + 1 >= w) begin
         scan_col = 0;
         if (scan_row < ROW_LIMIT) scan_row = ir + 1;
      end else begin
         scan_col = ic + 1;
      end
   endtask

   task automatic send_pixel(input logic [PIX_W-1:0] gray, input logic [PIX_W-1:0] alpha,
                             input bit typed = 1'b0, input edge_word_type want = '0);
      bit            emit;
      edge_word_type word;
      req_tdata  <= {alpha, gray};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      predict_pixel(gray, alpha, emit, word);
      if (typed) edge_words_due.push_back(want);
      else if (emit) edge_words_due.push_back(word);
      if (idle_en && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // sizes change only once the pipeline has drained
   task automatic resize_frame(input logic [DIM_W-1:0] width, input logic [DIM_W-1:0] height);
      req_tvalid <= 1'b0;
      while (edge_words_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= REG_FRAME_WIDTH;
      csr_data  <= width;
      do @(posedge clock); while (!csr_ready);
      cfg_width = width;
      csr_index <= REG_FRAME_HEIGHT;
      csr_data  <= height;
      do @(posedge clock); while (!csr_ready);
      cfg_height = height;
      csr_valid <= 1'b0;
   endtask

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (sink_hold_cycles != 0) begin
            rsp_tready <= 1'b0;
            repeat (sink_hold_cycles) @(posedge clock);
            sink_hold_cycles = 0;
         end else if (idle_en && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (edge_words_due.size() == 0) begin
            report_mismatch($sformatf("word %h last %b with nothing pending",
                                      rsp_tdata, rsp_tlast));
         end else begin
            next_due = edge_words_due.pop_front();
            if (rsp_tdata[PIX_W-1:0] !== next_due.level)
               report_mismatch($sformatf("edge level %0d, want %0d",
                                         rsp_tdata[PIX_W-1:0], next_due.level));
            if (rsp_tdata[2*PIX_W-1:PIX_W] !== next_due.alpha)
               report_mismatch($sformatf("edge alpha %0d, want %0d",
                                         rsp_tdata[2*PIX_W-1:PIX_W], next_due.alpha));
            if (rsp_tlast !== next_due.done)
               report_mismatch($sformatf("frame done %b, want %b", rsp_tlast, next_due.done));
         end
      end
   end

   initial begin
      logic [PIX_W-1:0] gray_v;
      logic [DIM_W-1:0] wv, hv;
      int unsigned      fw, fh, n, phase;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = REG_FRAME_WIDTH;
      csr_data   = '0;
      foreach (line_above[i]) line_above[i] = '0;
      foreach (line_two_above[i]) line_two_above[i] = '0;
      foreach (window3[i]) window3[i] = '0;
      alpha_lag[0] = '0;
      alpha_lag[1] = '0;
      scan_col   = 0;
      scan_row   = 0;
      cfg_width  = FRAME_WIDTH_RESET;
      cfg_height = FRAME_HEIGHT_RESET;
      gray_v     = '0;

      // reset sizes, then a mid-frame change to 1 x 1
      directed_rows.push_back('{ROW_PIXEL, 11'h000, 11'h000, 1'b0, '0});
      directed_rows.push_back('{ROW_PIXEL, 11'h0FF, 11'h0FF, 1'b0, '0});
      directed_rows.push_back('{ROW_PIXEL, 11'h0AA, 11'h055, 1'b0, '0});
      directed_rows.push_back('{ROW_SIZES, 11'd1, 11'd1, 1'b0, '0});
      directed_rows.push_back('{ROW_PIXEL, 11'h012, 11'h034, 1'b0, '0});
      directed_rows.push_back('{ROW_PIXEL, 11'h056, 11'h078, 1'b0, '0});
      directed_rows.push_back('{ROW_PIXEL, 11'h09A, 11'h0BC, 1'b0, '0});
      // one pixel frames: every neighbor masked, level zero, pixel alpha, frame done
      directed_rows.push_back('{ROW_PIXEL, 11'h0FF, 11'h081, 1'b0, '0});
      directed_rows.push_back('{ROW_PIXEL, 11'h000, 11'h0FF, 1'b0, '0});
      directed_rows.push_back('{ROW_PIXEL, 11'h000, 11'h000, 1'b1, '{8'h00, 8'h81, 1'b1}});
      directed_rows.push_back('{ROW_PIXEL, 11'h000, 11'h07E, 1'b0, '0});
      directed_rows.push_back('{ROW_PIXEL, 11'h0FF, 11'h000, 1'b0, '0});
      directed_rows.push_back('{ROW_PIXEL, 11'h0FF, 11'h0FF, 1'b1, '{8'h00, 8'h7E, 1'b1}});
      // 3 x 3 frame with a bright center, then trailing words
      directed_rows.push_back('{ROW_SIZES, 11'd3, 11'd3, 1'b0, '0});
      for (int i = 0; i < 9; i++)
         directed_rows.push_back('{ROW_PIXEL, (i == 4) ? 11'h0FF : 11'h000, 11'(i + 1),
                                   1'b0, '0});
      for (int i = 0; i < 4; i++)
         directed_rows.push_back('{ROW_PIXEL, 11'h0FF, 11'h0F0 + 11'(i), 1'b0, '0});

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_SIZES)
            resize_frame(directed_rows[i].a, directed_rows[i].b);
         else
            send_pixel(directed_rows[i].a[PIX_W-1:0], directed_rows[i].b[PIX_W-1:0],
                       directed_rows[i].typed, directed_rows[i].want);
      end

      phase = 0;
      while (items_sent < 1560) begin
         if (phase == 5) begin
            wv = ROW_LIMIT;
            hv = ROW_LIMIT;
         end else if (phase == 3) begin
            wv = 11'd8;
            hv = 11'd6;
         end else begin
            case ($urandom_range(0, 7))
               0:       wv = 11'd0;
               1:       wv = 11'd1;
               default: wv = DIM_W'($urandom_range(2, 9));
            endcase
            case ($urandom_range(0, 9))
               0:       hv = 11'd0;
               1:       hv = 11'd1;
               2:       hv = DIM_W'(MAX_H);
               3:       hv = ROW_LIMIT;
               default: hv = DIM_W'($urandom_range(2, 6));
            endcase
         end
         resize_frame(wv, hv);
         fw = effective_dim(wv, MAX_W);
         fh = effective_dim(hv, MAX_H);
         if (phase == 5) begin
            n = MAX_W + 6;
         end else if (fh > 8) begin
            n = $urandom_range(fw + 2, 6 * fw + 12);
         end else begin
            n = $urandom_range(1, 3) * (fw * fh + fw + 1);
            if ($urandom_range(0, 3) == 0) n += $urandom_range(1, fw * fh);
         end
         // long receiver stall while the sender keeps offering words
         if (phase == 3) sink_hold_cycles = 300;
         if (items_sent > 1250) idle_en = 1'b0;
         repeat (n) begin
            case ($urandom_range(0, 4))
               0:       gray_v = '0;
               1:       gray_v = LEVEL_SAT;
               2:       gray_v = PIX_W'($urandom_range(0, 255));
               default: gray_v = gray_v + PIX_W'($urandom_range(0, 15)) - PIX_W'(8);
            endcase
            send_pixel(gray_v, PIX_W'($urandom_range(0, 255)));
         end
         phase++;
      end

      req_tvalid <= 1'b0;
      while (edge_words_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
design/sem_pkg.sv
design/sem_line_store.sv
design/sem_window.sv
design/sem_isqrt.sv
design/sobel_edge_magnitude.sv
design/sem_checker.sv
verif/tb_sobel_edge_magnitude.sv
